>>> rtl/sbq_pkg.sv
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared types and constants for the stereo biquad filter: item payloads,
// coefficient set, register indexes and reset values.
// ----------------------------------------------------------------------------
package sbq_pkg;

    // Sample and history widths
    localparam int SAMPLE_W = 16;   // PCM sample
    localparam int COEF_W   = 32;   // Q4.28 coefficient
    localparam int HIST_W   = 48;   // Q32.16 output history
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B0 = 3'd0,
        CFG_B1 = 3'd1,
        CFG_B2 = 3'd2,
        CFG_A1 = 3'd3,
        CFG_A2 = 3'd4
    } t_cfg_idx;

    // Coefficient reset values (b0 = 1.0, all others 0)
    localparam logic signed [COEF_W-1:0] COEF_B0_RESET = 32'sh1000_0000;
    localparam logic signed [COEF_W-1:0] COEF_ZERO     = 32'sh0000_0000;

    // Shared coefficient set
    typedef struct packed {
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_coefs;

    // Input item: one stereo frame
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_item;

    // Result item: one filtered stereo frame
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_filtered;
        logic signed [SAMPLE_W-1:0] right_filtered;
    } t_out_item;

endpackage

>>> rtl/sbq_coef_regs.sv
// ----------------------------------------------------------------------------
// sbq_coef_regs
// Coefficient register file. Five Q4.28 registers written through a plain
// write port; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
module sbq_coef_regs
    import sbq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data,
    output t_coefs               o_coefs
);

    t_coefs r_coefs;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= COEF_B0_RESET;
            r_coefs.b1 <= COEF_ZERO;
            r_coefs.b2 <= COEF_ZERO;
            r_coefs.a1 <= COEF_ZERO;
            r_coefs.a2 <= COEF_ZERO;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_B0:  r_coefs.b0 <= $signed(i_cfg_data);
                CFG_B1:  r_coefs.b1 <= $signed(i_cfg_data);
                CFG_B2:  r_coefs.b2 <= $signed(i_cfg_data);
                CFG_A1:  r_coefs.a1 <= $signed(i_cfg_data);
                CFG_A2:  r_coefs.a2 <= $signed(i_cfg_data);
                default: ;  // unused index, ignore
            endcase
        end
    end

    assign o_coefs = r_coefs;

endmodule

>>> rtl/sbq_channel.sv
// ----------------------------------------------------------------------------
// sbq_channel
// One direct-form-I biquad section: history registers plus the combinational
// multiply/accumulate, 48-bit saturation and conversion to a 16-bit sample.
// ----------------------------------------------------------------------------
module sbq_channel
    import sbq_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,   // item moves to result reg
    input  logic signed [SAMPLE_W-1:0] i_x,
    input  t_coefs                     i_coefs,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    localparam int FF_W  = COEF_W + SAMPLE_W;       // raw feedforward product
    localparam int FB_W  = COEF_W + HIST_W;         // raw feedback product
    localparam int FBQ_W = FB_W - 28;               // after floor to Q.16
    localparam int ACC_W = 56;
    localparam int INT_W = HIST_W - 16;

    // History
    logic signed [SAMPLE_W-1:0] r_x1, r_x2;
    logic signed [HIST_W-1:0]   r_y1, r_y2;

    logic signed [FF_W-1:0]  w_ff0, w_ff1, w_ff2;
    logic signed [FBQ_W-1:0] w_fb1, w_fb2;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [HIST_W-1:0] n_y;
    logic signed [INT_W-1:0] w_int;

    // floor(c * y / 2^28), y split into a signed high word and an unsigned
    // 16-bit low part so each multiplier stays at 32 bits or less
    function automatic logic signed [FBQ_W-1:0] fb_term(
        input logic signed [COEF_W-1:0] c,
        input logic signed [HIST_W-1:0] y
    );
        logic signed [INT_W-1:0]  yh;
        logic signed [16:0]       yl;
        logic signed [COEF_W+INT_W-1:0] ph;
        logic signed [COEF_W+16:0]      pl;
        logic signed [FB_W-1:0]   p_hi;
        logic signed [FB_W-1:0]   p_lo;
        logic signed [FB_W-1:0]   p;
        yh   = y[HIST_W-1:16];
        yl   = $signed({1'b0, y[15:0]});
        ph   = c * yh;
        pl   = c * yl;
        p_hi = {ph, 16'h0000};
        p_lo = FB_W'(pl);
        p    = p_hi + p_lo;
        return p[FB_W-1:28];
    endfunction

    // Products
    always_comb begin
        w_ff0 = i_coefs.b0 * i_x;
        w_ff1 = i_coefs.b1 * r_x1;
        w_ff2 = i_coefs.b2 * r_x2;
        w_fb1 = fb_term(i_coefs.a1, r_y1);
        w_fb2 = fb_term(i_coefs.a2, r_y2);
    end

    // Accumulate with each term floored to Q.16, then saturate to 48 bits
    always_comb begin
        w_acc = ACC_W'($signed(w_ff0[FF_W-1:12])) + ACC_W'($signed(w_ff1[FF_W-1:12]))
              + ACC_W'($signed(w_ff2[FF_W-1:12])) - ACC_W'(w_fb1) - ACC_W'(w_fb2);
        if (w_acc[ACC_W-1:HIST_W-1] == '0 || w_acc[ACC_W-1:HIST_W-1] == '1) begin
            n_y = w_acc[HIST_W-1:0];
        end else if (w_acc[ACC_W-1]) begin
            n_y = {1'b1, {(HIST_W-1){1'b0}}};
        end else begin
            n_y = {1'b0, {(HIST_W-1){1'b1}}};
        end
    end

    // Truncate toward zero, then clamp to the 16-bit range
    always_comb begin
        w_int = n_y[HIST_W-1:16];
        if (n_y[HIST_W-1] && (|n_y[15:0])) begin
            w_int = w_int + INT_W'(1);
        end
        if (w_int[INT_W-1:SAMPLE_W-1] == '0 || w_int[INT_W-1:SAMPLE_W-1] == '1) begin
            o_sample = w_int[SAMPLE_W-1:0];
        end else if (w_int[INT_W-1]) begin
            o_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            o_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    // History shift when the item moves on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_advance) begin
            r_x1 <= i_x;
            r_x2 <= r_x1;
            r_y1 <= n_y;
            r_y2 <= r_y1;
        end
    end

endmodule

>>> rtl/stereo_biquad_filter_core.sv
// ----------------------------------------------------------------------------
// stereo_biquad_filter_core
// Stereo direct-form-I biquad: one frame of two samples in, one filtered
// frame out, both channels sharing one Q4.28 coefficient set.
// ----------------------------------------------------------------------------
//  Port group   Dir  Handshake              Payload
//  in           in   i_in_valid/o_in_stall  i_in_data  (t_in_item)
//  out          out  o_out_valid/i_out_stall o_out_data (t_out_item)
//  cfg          in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// One item per cycle sustained while i_out_stall stays low; an accepted item
// is held in the input register, then registered into the result register.
// The feedback multiply/accumulate on the 48-bit history sets the cycle time.
// Synchronous active-low reset clears history, valids and b1..a2; b0 = 1.0.
// A full result register under stall still lets one more item into the
// input register; only when both are full is o_in_stall raised.
// ----------------------------------------------------------------------------
module stereo_biquad_filter_core
    import sbq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_W-1:0]    i_cfg_data
);

    t_coefs    w_coefs;
    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;
    t_out_item w_result;
    logic signed [SAMPLE_W-1:0] w_left;
    logic signed [SAMPLE_W-1:0] w_right;
    logic      w_accept;
    logic      w_advance;

    // Coefficients
    sbq_coef_regs u_coef_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coefs    (w_coefs)
    );

    // Handshake
    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Channel datapaths
    sbq_channel u_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_x       (r_in_data.left_sample),
        .i_coefs   (w_coefs),
        .o_sample  (w_left)
    );

    sbq_channel u_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_x       (r_in_data.right_sample),
        .i_coefs   (w_coefs),
        .o_sample  (w_right)
    );

    assign w_result = {w_left, w_right};

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Checks
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_in_valid)
        else $error("accepted item not held in input register");

    a_advance_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("computed result not presented");

    a_reset_coefs: assert property (@(posedge i_clk)
        !i_rst_n |=> (w_coefs.b0 == COEF_B0_RESET && w_coefs.b1 == COEF_ZERO
                      && w_coefs.b2 == COEF_ZERO && w_coefs.a1 == COEF_ZERO
                      && w_coefs.a2 == COEF_ZERO))
        else $error("coefficients not at reset values");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for stereo_biquad_filter_core. A directed table walks
// the sample extremes, every coefficient register, unmapped register indexes
// and an unstable filter that drives the history into saturation. Random
// stereo frames then run under several coefficient sets: stable filters,
// raw random patterns and full-scale extremes. Every filtered item is checked
// field by field against a bit-exact fixed-point model or a directed row's values.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sbq_pkg::*;

    localparam int unsigned NUM_COEFS       = 5;
    localparam int unsigned IDX_SPARE_FIRST = NUM_COEFS;
    localparam int unsigned IDX_SPARE_LAST  = (1 << CFG_IDX_W) - 1;
    localparam int          DIR_ROWS        = 26;
    localparam int          NUM_SETS        = 6;
    localparam int          SET_FRAMES      = 250;
    localparam int          STEADY_FIRST    = 600;
    localparam int          STEADY_LAST     = 900;
    localparam int          IDLE_PCT        = 25;
    localparam int          DRAIN_CYCLES    = 4;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          MAX_REPORTS     = 10;
    localparam int          RESET_CYCLES    = 11;

    // Fixed-point scaling of the datapath
    localparam int FF_SHIFT = 12;   // Q4.28 * Q16.0 -> Q.16
    localparam int FB_SHIFT = 28;   // Q4.28 * Q32.16 -> Q.16
    localparam int FRAC_W   = 16;

    localparam logic [COEF_W-1:0] COEF_MAX  = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_MIN  = 32'h8000_0000;
    localparam logic [COEF_W-1:0] COEF_NEG1 = 32'hFFFF_FFFF;
    localparam logic [COEF_W-1:0] COEF_HALF = 32'h0800_0000;

    // Wide enough for any coefficient times any history value
    typedef logic signed [95:0] t_wide;
    localparam t_wide HIST_MAX = 96'sh7FFF_FFFF_FFFF;
    localparam t_wide HIST_MIN = -HIST_MAX - 1;
    localparam t_wide PCM_MAX  = 32767;
    localparam t_wide PCM_MIN  = -32768;

    typedef enum logic [1:0] {SET_STABLE, SET_WILD, SET_EXTREME} t_set_kind;
    typedef enum logic {ROW_FRAME, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind                  kind;
        int unsigned                idx;
        logic [COEF_W-1:0]          coef;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        bit                         known;
        logic signed [SAMPLE_W-1:0] want_left;
        logic signed [SAMPLE_W-1:0] want_right;
    } t_stim_row;

    // DUT ports
    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    t_in_item             i_in_data;
    logic                 o_out_valid;
    logic                 i_out_stall;
    t_out_item            o_out_data;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COEF_W-1:0]    i_cfg_data;

    // Filter model state
    logic signed [COEF_W-1:0]   coef_now [NUM_COEFS];
    logic signed [SAMPLE_W-1:0] x_hist [4];
    logic signed [HIST_W-1:0]   y_hist [4];
    t_out_item                  expected_q [$];

    t_stim_row dir_rows [DIR_ROWS];
    t_out_item front_want;
    bit        steady;
    int        mismatches;
    int        frames_sent;
    int        results_checked;
    int        fullscale_results;
    int        coef_sets;
    int        cycles;

    stereo_biquad_filter_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // floor(c * v / 2^shift), exact
    function automatic t_wide scaled_product(logic signed [COEF_W-1:0] c, t_wide v,
                                             int shift);
        t_wide cw;
        cw = c;
        return (cw * v) >>> shift;
    endfunction

    // One channel of the direct-form-I section; advances that channel's history
    function automatic logic signed [SAMPLE_W-1:0] filter_channel(
        int ch, logic signed [SAMPLE_W-1:0] x0);
        t_wide x0w, x1w, x2w, y1w, y2w, acc, whole;
        x0w = x0;
        x1w = x_hist[2*ch];
        x2w = x_hist[2*ch+1];
        y1w = y_hist[2*ch];
        y2w = y_hist[2*ch+1];
        acc = scaled_product(coef_now[CFG_B0], x0w, FF_SHIFT)
            + scaled_product(coef_now[CFG_B1], x1w, FF_SHIFT)
            + scaled_product(coef_now[CFG_B2], x2w, FF_SHIFT)
            - scaled_product(coef_now[CFG_A1], y1w, FB_SHIFT)
            - scaled_product(coef_now[CFG_A2], y2w, FB_SHIFT);
        if (acc > HIST_MAX) begin
            acc = HIST_MAX;
        end else if (acc < HIST_MIN) begin
            acc = HIST_MIN;
        end
        x_hist[2*ch+1] = x_hist[2*ch];
        x_hist[2*ch]   = x0;
        y_hist[2*ch+1] = y_hist[2*ch];
        y_hist[2*ch]   = acc[HIST_W-1:0];
        // truncate toward zero, then clamp to PCM range
        whole = (acc < 0) ? -((-acc) >>> FRAC_W) : (acc >>> FRAC_W);
        if (whole > PCM_MAX) begin
            whole = PCM_MAX;
        end else if (whole < PCM_MIN) begin
            whole = PCM_MIN;
        end
        return whole[SAMPLE_W-1:0];
    endfunction

    function automatic t_out_item biquad_frame(t_in_item d);
        t_out_item r;
        r.left_filtered  = filter_channel(0, d.left_sample);
        r.right_filtered = filter_channel(1, d.right_sample);
        return r;
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(t_set_kind kind, int unsigned idx);
        logic [COEF_W-1:0] v;
        case (kind)
            SET_STABLE: begin
                // |a1| <= 1, 0 <= a2 <= 0.5 keeps the poles in the closed unit disk
                if (idx == CFG_A2) begin
                    v = $urandom_range(COEF_HALF);
                end else begin
                    v = (idx == CFG_A1) ? $urandom_range(COEF_B0_RESET)
                                        : $urandom_range(COEF_HALF);
                    if ($urandom_range(1)) v = -v;
                end
            end
            SET_WILD: begin
                v = $urandom();
            end
            default: begin
                case ($urandom_range(3))
                    0:       v = COEF_MAX;
                    1:       v = COEF_MIN;
                    2:       v = COEF_NEG1;
                    default: v = COEF_ZERO;
                endcase
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(3))
                    0:       s = 16'sh7FFF;
                    1:       s = 16'sh8000;
                    2:       s = 16'shFFFF;
                    default: s = 16'sh0000;
                endcase
            end
            1:       s = 16'(int'($urandom_range(512)) - 256);
            default: s = 16'($urandom());
        endcase
        return s;
    endfunction

    // Register write; only issued once every filtered item has come back
    task automatic cfg_write(int unsigned idx, logic [COEF_W-1:0] value);
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx[CFG_IDX_W-1:0];
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx < NUM_COEFS) coef_now[idx] = value;
    endtask

    // Present one frame until accepted, with random idle cycles ahead of it unless steady
    task automatic send_frame(t_in_item d);
        i_cfg_we <= 1'b0;
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        frames_sent++;
    endtask

    // Result checker and output stall generator
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: filtered item with none pending: L=%0d R=%0d",
                             o_out_data.left_filtered, o_out_data.right_filtered);
            end else begin
                front_want = expected_q.pop_front();
                if (o_out_data.left_filtered !== front_want.left_filtered ||
                    o_out_data.right_filtered !== front_want.right_filtered) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("ERROR: item %0d: L exp %0d got %0d, R exp %0d got %0d",
                                 results_checked,
                                 front_want.left_filtered, o_out_data.left_filtered,
                                 front_want.right_filtered, o_out_data.right_filtered);
                end
                if (front_want.left_filtered == PCM_MAX ||
                    front_want.left_filtered == PCM_MIN ||
                    front_want.right_filtered == PCM_MAX ||
                    front_want.right_filtered == PCM_MIN)
                    fullscale_results++;
                results_checked++;
            end
        end
        i_out_stall <= (i_rst_n && !steady) ? ($urandom_range(99) < IDLE_PCT) : 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("ERROR: timeout with %0d items outstanding", expected_q.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus
    initial begin
        t_in_item  d;
        t_out_item model;
        t_set_kind kind;
        int        rand_sent;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_data  <= '0;
        steady      <= 1'b0;
        cycles      = 0;
        mismatches  = 0;
        rand_sent   = 0;

        // model state after reset: unity gain, empty history
        coef_now[CFG_B0] = COEF_B0_RESET;
        coef_now[CFG_B1] = COEF_ZERO;
        coef_now[CFG_B2] = COEF_ZERO;
        coef_now[CFG_A1] = COEF_ZERO;
        coef_now[CFG_A2] = COEF_ZERO;
        foreach (x_hist[k]) begin
            x_hist[k] = '0;
            y_hist[k] = '0;
        end

        dir_rows = '{
            // reset coefficients pass samples through unchanged
            '{ROW_FRAME, 0, '0, 16'sh0000, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
            '{ROW_FRAME, 0, '0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000},
            '{ROW_FRAME, 0, '0, 16'sh8000, 16'sh7FFF, 1'b1, 16'sh8000, 16'sh7FFF},
            '{ROW_FRAME, 0, '0, 16'shFFFF, 16'sh0001, 1'b1, 16'shFFFF, 16'sh0001},
            '{ROW_FRAME, 0, '0, 16'sh5555, 16'shAAAA, 1'b1, 16'sh5555, 16'shAAAA},
            // full-scale coefficients: unstable, history saturates
            '{ROW_WRITE, CFG_B0, COEF_MAX, '0, '0, 1'b0, '0, '0},
            '{ROW_WRITE, CFG_B1, COEF_MIN, '0, '0, 1'b0, '0, '0},
            '{ROW_WRITE, CFG_B2, COEF_MAX, '0, '0, 1'b0, '0, '0},
            '{ROW_WRITE, CFG_A1, COEF_MIN, '0, '0, 1'b0, '0, '0},
            '{ROW_WRITE, CFG_A2, COEF_MAX, '0, '0, 1'b0, '0, '0},
            // unmapped indexes must be ignored
            '{ROW_WRITE, IDX_SPARE_FIRST, COEF_ZERO, '0, '0, 1'b0, '0, '0},
            '{ROW_WRITE, IDX_SPARE_LAST, COEF_NEG1, '0, '0, 1'b0, '0, '0},
            '{ROW_FRAME, 0, '0, 16'sh7FFF, 16'sh8000, 1'b0, '0, '0},
            '{ROW_FRAME, 0, '0, 16'sh7FFF, 16'sh8000, 1'b0, '0, '0},
            '{ROW_FRAME, 0, '0, 16'sh8000, 16'sh7FFF, 1'b0, '0, '0},
            '{ROW_FRAME, 0, '0, 16'sh0000, 16'sh0000, 1'b0, '0, '0},
            '{ROW_FRAME, 0, '0, 16'sh0000, 16'sh0000, 1'b0, '0, '0},
            // two-tap average: half-LSB negatives truncate toward zero
            '{ROW_WRITE, CFG_A1, COEF_ZERO, '0, '0, 1'b0, '0, '0},
            '{ROW_WRITE, CFG_A2, COEF_ZERO, '0, '0, 1'b0, '0, '0},
            '{ROW_WRITE, CFG_B0, COEF_HALF, '0, '0, 1'b0, '0, '0},
            '{ROW_WRITE, CFG_B1, COEF_HALF, '0, '0, 1'b0, '0, '0},
            '{ROW_WRITE, CFG_B2, COEF_ZERO, '0, '0, 1'b0, '0, '0},
            '{ROW_FRAME, 0, '0, 16'shFFFF, 16'sh0001, 1'b0, '0, '0},
            '{ROW_FRAME, 0, '0, 16'shFFFF, 16'sh0001, 1'b0, '0, '0},
            '{ROW_FRAME, 0, '0, 16'sh0003, 16'shFFFD, 1'b0, '0, '0},
            '{ROW_FRAME, 0, '0, 16'sh0000, 16'sh0000, 1'b0, '0, '0}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_WRITE) begin
                cfg_write(dir_rows[r].idx, dir_rows[r].coef);
            end else begin
                d.left_sample  = dir_rows[r].left;
                d.right_sample = dir_rows[r].right;
                send_frame(d);
                model = biquad_frame(d);
                if (dir_rows[r].known) begin
                    model.left_filtered  = dir_rows[r].want_left;
                    model.right_filtered = dir_rows[r].want_right;
                end
                expected_q.push_back(model);
            end
        end

        // random frames under a sequence of coefficient sets
        for (int s = 0; s < NUM_SETS; s++) begin
            kind = t_set_kind'(s % 3);
            for (int unsigned c = 0; c < NUM_COEFS; c++)
                cfg_write(c, pick_coef(kind, c));
            coef_sets++;
            for (int k = 0; k < SET_FRAMES; k++) begin
                steady <= (rand_sent >= STEADY_FIRST && rand_sent < STEADY_LAST);
                d.left_sample  = pick_sample();
                d.right_sample = pick_sample();
                send_frame(d);
                expected_q.push_back(biquad_frame(d));
                rand_sent++;
            end
        end
        i_in_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Filtered %0d stereo frames over %0d random coefficient sets plus directed cases",
                 frames_sent, coef_sets);
        $display("%0d items checked, %0d with a channel at full scale, %0d mismatches",
                 results_checked, fullscale_results, mismatches);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
